@@ hdl/prs_pkg.sv @@
package prs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int VAL_WIDTH      = 48;

    typedef enum logic [2:0] {
        ST_TWO_REAL = 3'd0,
        ST_REPEATED = 3'd1,
        ST_COMPLEX  = 3'd2,
        ST_LEAD_ZERO = 3'd3,
        ST_LINEAR   = 3'd4
    } status_t;

    localparam logic OP_LINEAR = 1'b0;
    localparam logic OP_QUAD   = 1'b1;

endpackage

@@ hdl/prs_if.sv @@
interface prs_if #(
    parameter int W = 1
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/prs_front.sv @@
// Front end: sign-extend coefficients, form the discriminant in two stages.
module prs_front #(
    parameter int CW = prs_pkg::COEF_WIDTH_DEF,
    parameter int QW = 4 * CW + 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic signed [CW-1:0]  coef_a,
    input  logic signed [CW-1:0]  coef_b,
    input  logic signed [CW-1:0]  coef_c,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [QW-1:0]         out_data
);
    import prs_pkg::*;

    localparam int PW = 2 * CW + 3;

    logic                 v1_reg, v2_reg;
    logic                 op1_reg, op2_reg;
    logic signed [CW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [PW-1:0] bb_reg, ac_reg, d_reg;
    logic                 adv1, adv2;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            op1_reg <= opcode;
            a1_reg  <= coef_a;
            b1_reg  <= coef_b;
            bb_reg  <= PW'(coef_b * coef_b);
            ac_reg  <= PW'(coef_a * coef_c);
        end
        if (adv2 && v1_reg)
        begin
            op2_reg <= op1_reg;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            d_reg   <= bb_reg - (ac_reg <<< 2);
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = QW'({op2_reg, a2_reg, b2_reg, d_reg});
endmodule

@@ hdl/prs_fifo.sv @@
// Small queue between front and back ends.
module prs_fifo #(
    parameter int W = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_data;
    end
endmodule

@@ hdl/prs_back.sv @@
// Back end: bit-serial square root, then up to two restoring divides on one unit.
module prs_back #(
    parameter int CW = prs_pkg::COEF_WIDTH_DEF,
    parameter int FB = prs_pkg::FRAC_BITS_DEF,
    parameter int QW = 4 * CW + 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [QW-1:0]              in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output prs_pkg::status_t           status,
    output logic signed [prs_pkg::VAL_WIDTH-1:0] first_value,
    output logic signed [prs_pkg::VAL_WIDTH-1:0] second_value
);
    import prs_pkg::*;

    localparam int PW  = 2 * CW + 3;
    localparam int RW  = PW / 2 + FB + 2;           // root width
    localparam int NSQ = (PW + 1) / 2 + FB;         // root steps
    localparam int NW  = CW + FB + 2;               // numerator magnitude width
    localparam int NMW = (NW > RW ? NW : RW) + 1;
    localparam int DW  = CW + 1;                    // divisor magnitude width
    localparam int SCW = $clog2(NSQ + NMW + 1);
    localparam int RMW = RW + 3;

    typedef enum logic [1:0] { S_IDLE, S_SQRT, S_DIV, S_DONE } state_t;

    state_t                state_reg;
    logic                  second_reg;
    logic [SCW-1:0]        cnt_reg;
    logic                  op_reg;
    logic signed [CW-1:0]  a_reg, b_reg;
    logic [PW-1:0]         mag_reg;
    logic [RW-1:0]         root_reg;
    logic [RMW-1:0]        rem_reg;
    logic [NMW-1:0]        quo_reg;
    logic [DW:0]           drem_reg;
    logic                  neg_reg;
    status_t               st_reg;
    logic signed [VAL_WIDTH-1:0] v1_reg, v2_reg;
    logic                  ov_reg;

    logic signed [CW-1:0]  a_in, b_in;
    logic signed [PW-1:0]  d_in;
    logic                  op_in;
    logic [1:0]            pair;
    logic [RMW-1:0]        rem_sh, trial;
    logic [DW-1:0]         dmag;
    logic [DW:0]           dsh;
    logic signed [NMW:0]   nb, num;
    logic signed [NMW:0]   sroot;

    assign {op_in, a_in, b_in, d_in} = in_data[1 + 2 * CW + PW - 1:0];
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = ov_reg;

    always_comb
    begin
        pair = 2'b00;
        if (cnt_reg >= SCW'(FB))
            pair = 2'(mag_reg >> (2 * (int'(cnt_reg) - FB)));
    end
    assign rem_sh = {rem_reg[RMW-3:0], pair};
    assign trial  = RMW'({root_reg, 2'b01});

    assign dmag  = (op_reg == OP_LINEAR)
                 ? DW'(a_reg[CW-1] ? -a_reg : a_reg)
                 : DW'(a_reg[CW-1] ? -(DW'(a_reg) <<< 1) : (DW'(a_reg) <<< 1));
    assign dsh   = {drem_reg[DW-1:0], quo_reg[NMW-1]};
    assign nb    = -((NMW+1)'(b_reg) <<< FB);
    assign sroot = (NMW+1)'(root_reg);
    always_comb
    begin
        if (op_reg == OP_LINEAR || st_reg == ST_REPEATED || (st_reg == ST_COMPLEX && !second_reg))
            num = nb;
        else if (st_reg == ST_COMPLEX)
            num = sroot;
        else if (!second_reg)
            num = nb + sroot;
        else
            num = nb - sroot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready && state_reg != S_DONE)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg     <= op_in;
                        a_reg      <= a_in;
                        b_reg      <= b_in;
                        mag_reg    <= PW'(d_in[PW-1] ? -d_in : d_in);
                        root_reg   <= '0;
                        rem_reg    <= '0;
                        second_reg <= 1'b0;
                        v1_reg     <= '0;
                        v2_reg     <= '0;
                        if (a_in == '0)
                        begin
                            st_reg    <= ST_LEAD_ZERO;
                            state_reg <= S_DONE;
                        end
                        else if (op_in == OP_LINEAR)
                        begin
                            st_reg    <= ST_LINEAR;
                            state_reg <= S_DIV;
                            cnt_reg   <= '1;
                        end
                        else if (d_in == '0)
                        begin
                            st_reg    <= ST_REPEATED;
                            state_reg <= S_DIV;
                            cnt_reg   <= '1;
                        end
                        else
                        begin
                            st_reg    <= d_in[PW-1] ? ST_COMPLEX : ST_TWO_REAL;
                            state_reg <= S_SQRT;
                            cnt_reg   <= SCW'(NSQ - 1);
                        end
                    end
                end
                S_SQRT:
                begin
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[RW-2:0], 1'b0};
                    end
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_DIV;
                        cnt_reg   <= '1;
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                S_DIV:
                begin
                    if (cnt_reg == '1)
                    begin
                        // load numerator magnitude; sign of quotient
                        quo_reg  <= NMW'(num[NMW] ? -num : num);
                        neg_reg  <= num[NMW] ^ a_reg[CW-1];
                        drem_reg <= '0;
                        cnt_reg  <= SCW'(NMW - 1);
                    end
                    else
                    begin
                        if (dsh >= (DW+1)'(dmag))
                        begin
                            drem_reg <= dsh - (DW+1)'(dmag);
                            quo_reg  <= {quo_reg[NMW-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= dsh;
                            quo_reg  <= {quo_reg[NMW-2:0], 1'b0};
                        end
                        if (cnt_reg == '0)
                        begin
                            if (!second_reg)
                                v1_reg <= neg_reg
                                    ? -VAL_WIDTH'({quo_reg[NMW-2:0], dsh >= (DW+1)'(dmag)})
                                    : VAL_WIDTH'({quo_reg[NMW-2:0], dsh >= (DW+1)'(dmag)});
                            else
                                v2_reg <= neg_reg
                                    ? -VAL_WIDTH'({quo_reg[NMW-2:0], dsh >= (DW+1)'(dmag)})
                                    : VAL_WIDTH'({quo_reg[NMW-2:0], dsh >= (DW+1)'(dmag)});
                            if (!second_reg && (st_reg == ST_TWO_REAL || st_reg == ST_COMPLEX))
                            begin
                                second_reg <= 1'b1;
                                cnt_reg    <= '1;
                            end
                            else
                                state_reg <= S_DONE;
                        end
                        else
                            cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg       <= 1'b1;
                        status       <= st_reg;
                        first_value  <= v1_reg;
                        second_value <= v2_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/polynomial_root_solver.sv @@
// Linear / quadratic root solver. Each item (opcode, a, b, c) yields one result: status
// and two signed 48-bit fixed-point values with FRAC_BITS fractional bits. A two-stage
// front end forms D = b*b - 4ac and hands items through a four-entry queue to a back end
// that runs a bit-serial square root (one root bit per cycle, (2*COEF_WIDTH+4)/2+FRAC_BITS
// root steps) and a shared restoring divider (a load step, then one quotient bit per cycle;
// two quotients for real or complex pairs, one for a repeated root or a linear item). A
// leading-zero item skips both. The back end takes a new item only when idle, once the
// previous result is in its output register, where it may wait for the sink. Throughput
// is set by the back end.
module polynomial_root_solver #(
    parameter int COEF_WIDTH = prs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = prs_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    prs_if.sink  in_ch,
    prs_if.source out_ch
);
    import prs_pkg::*;

    localparam int QW = 4 * COEF_WIDTH + 4;

    logic          f_valid, f_ready, q_valid, q_ready;
    logic [QW-1:0] f_data, q_data;
    status_t       st;
    logic signed [VAL_WIDTH-1:0] v1, v2;

    // Input item layout: {coef_c, coef_b, coef_a, opcode}
    prs_front #(.CW(COEF_WIDTH), .QW(QW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .opcode(in_ch.data[0]),
        .coef_a(in_ch.data[COEF_WIDTH:1]),
        .coef_b(in_ch.data[2*COEF_WIDTH:COEF_WIDTH+1]),
        .coef_c(in_ch.data[3*COEF_WIDTH:2*COEF_WIDTH+1]),
        .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
    );

    prs_fifo #(.W(QW), .DEPTH(4)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    prs_back #(.CW(COEF_WIDTH), .FB(FRAC_BITS), .QW(QW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .status(st), .first_value(v1), .second_value(v2)
    );

    // Output item layout: {second_value, first_value, status}
    assign out_ch.data = {v2, v1, st};
endmodule

@@ test/tb.sv @@
module tb;
    import prs_pkg::*;

    localparam int CW   = COEF_WIDTH_DEF;
    localparam int FB   = FRAC_BITS_DEF;
    localparam int IN_W = 1 + 3 * CW;
    localparam int OUT_W = 3 + 2 * VAL_WIDTH;
    localparam int N_RANDOM = 1750;
    localparam int QUIET_FROM = 1550;

    typedef struct packed {
        logic [VAL_WIDTH-1:0]  second_value;
        logic [VAL_WIDTH-1:0]  first_value;
        status_t               status;
    } roots_t;

    // one row of the directed table; known marks a row whose result is typed in
    typedef struct {
        logic          op;
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [CW-1:0] c;
        bit            known;
        roots_t        res;
    } row_t;

    logic clk;
    logic rst_n;

    prs_if #(.W(IN_W))  in_ch ();
    prs_if #(.W(OUT_W)) out_ch ();

    polynomial_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    roots_t pending_roots[$];
    int     n_fail;
    int     n_sent;
    int     n_seen;
    int     n_by_status[8];
    bit     quiet;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // floor square root of mag * 2^(2*FB), two radicand bits per step
    function automatic longint scaled_root(longint mag);
        longint root;
        longint rem;
        longint pair;
        longint trial;
        root = 0;
        rem  = 0;
        for (int i = 31 + FB; i >= 0; i--)
        begin
            pair = 0;
            if (i >= FB)
                pair = (mag >> (2 * (i - FB))) & 3;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic roots_t solve_roots(logic op, logic [CW-1:0] ra, logic [CW-1:0] rb,
                                           logic [CW-1:0] rc);
        roots_t r;
        longint a, b, c, nb, d, den, s, v1, v2;
        a  = longint'($signed(ra));
        b  = longint'($signed(rb));
        c  = longint'($signed(rc));
        nb = -b * (longint'(1) << FB);
        v1 = 0;
        v2 = 0;
        if (a == 0)
            r.status = ST_LEAD_ZERO;
        else if (op == OP_LINEAR)
        begin
            r.status = ST_LINEAR;
            v1 = nb / a;
        end
        else
        begin
            d   = b * b - 4 * a * c;
            den = 2 * a;
            if (d > 0)
            begin
                s = scaled_root(d);
                r.status = ST_TWO_REAL;
                v1 = (nb + s) / den;
                v2 = (nb - s) / den;
            end
            else if (d == 0)
            begin
                r.status = ST_REPEATED;
                v1 = nb / den;
            end
            else
            begin
                s = scaled_root(-d);
                r.status = ST_COMPLEX;
                v1 = nb / den;
                v2 = s / den;
            end
        end
        r.first_value  = v1[VAL_WIDTH-1:0];
        r.second_value = v2[VAL_WIDTH-1:0];
        return r;
    endfunction

    // hand one item to the block; valid stays high if the next item follows at once
    task automatic push_item(logic op, logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c,
                             bit known, roots_t res);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = int'($urandom_range(1, 13));
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {c, b, a, op};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_roots.push_back(known ? res : solve_roots(op, a, b, c));
        n_sent++;
    endtask

    // receiver: random stall bursts on ready, none near the end
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (quiet)
            out_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= int'($urandom_range(0, 12));
        end
        else
            out_ch.ready <= 1'b1;
    end

    // compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        roots_t got;
        roots_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = roots_t'(out_ch.data);
            n_seen++;
            if (pending_roots.size() == 0)
            begin
                $error("result with nothing expected: status %0d", got.status);
                n_fail++;
            end
            else
            begin
                want = pending_roots.pop_front();
                n_by_status[got.status]++;
                if (got.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    n_fail++;
                end
                if (got.first_value !== want.first_value)
                begin
                    $error("first_value expected %h actual %h",
                           want.first_value, got.first_value);
                    n_fail++;
                end
                if (got.second_value !== want.second_value)
                begin
                    $error("second_value expected %h actual %h",
                           want.second_value, got.second_value);
                    n_fail++;
                end
            end
        end
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #30000000;
        $display("timeout with %0d results outstanding", pending_roots.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic roots_t mk(status_t st, longint v1, longint v2);
        roots_t r;
        r.status       = st;
        r.first_value  = v1[VAL_WIDTH-1:0];
        r.second_value = v2[VAL_WIDTH-1:0];
        return r;
    endfunction

    initial
    begin
        row_t   rows[$];
        roots_t none;
        int     k, m, sel;
        logic [CW-1:0] a, b, c;
        logic   op;

        none = mk(ST_TWO_REAL, 0, 0);
        n_fail = 0;
        n_sent = 0;
        n_seen = 0;
        quiet  = 1'b0;
        foreach (n_by_status[i])
            n_by_status[i] = 0;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;

        // leading zero in both modes, simple linear and repeated roots typed in
        rows.push_back('{OP_LINEAR, 16'sd0, 16'sd5, 16'sd7, 1, mk(ST_LEAD_ZERO, 0, 0)});
        rows.push_back('{OP_QUAD, 16'sd0, -16'sd32768, 16'sd32767, 1,
                         mk(ST_LEAD_ZERO, 0, 0)});
        rows.push_back('{OP_LINEAR, 16'sd1, -16'sd1, 16'sd0, 1, mk(ST_LINEAR, 65536, 0)});
        rows.push_back('{OP_LINEAR, 16'sd1, 16'sd0, -16'sd1, 1, mk(ST_LINEAR, 0, 0)});
        rows.push_back('{OP_LINEAR, -16'sd1, 16'sd1, 16'sd9, 1, mk(ST_LINEAR, 65536, 0)});
        rows.push_back('{OP_QUAD, 16'sd1, 16'sd0, 16'sd0, 1, mk(ST_REPEATED, 0, 0)});
        rows.push_back('{OP_QUAD, 16'sd1, -16'sd2, 16'sd1, 1, mk(ST_REPEATED, 65536, 0)});
        // extremes and the remaining cases go through the predictor
        rows.push_back('{OP_LINEAR, -16'sd32768, -16'sd32768, 16'sd0, 0, none});
        rows.push_back('{OP_LINEAR, 16'sd32767, -16'sd32768, 16'sd0, 0, none});
        rows.push_back('{OP_LINEAR, 16'sd1, -16'sd32768, 16'sd0, 0, none});
        rows.push_back('{OP_LINEAR, 16'sd3, 16'sd1, 16'sd0, 0, none});
        rows.push_back('{OP_QUAD, 16'sd1, 16'sd0, -16'sd4, 0, none});
        rows.push_back('{OP_QUAD, 16'sd1, 16'sd0, 16'sd4, 0, none});
        rows.push_back('{OP_QUAD, -16'sd1, 16'sd0, 16'sd4, 0, none});
        rows.push_back('{OP_QUAD, -16'sd1, 16'sd2, -16'sd5, 0, none});
        rows.push_back('{OP_QUAD, 16'sd1, -16'sd32768, -16'sd32768, 0, none});
        rows.push_back('{OP_QUAD, -16'sd32768, -16'sd32768, 16'sd32767, 0, none});
        rows.push_back('{OP_QUAD, -16'sd32768, 16'sd0, -16'sd32768, 0, none});
        rows.push_back('{OP_QUAD, 16'sd32767, 16'sd32767, 16'sd32767, 0, none});
        rows.push_back('{OP_QUAD, 16'sd1, 16'sd0, -16'sd32768, 0, none});
        rows.push_back('{OP_QUAD, 16'sd1, 16'sd1, 16'sd0, 0, none});
        rows.push_back('{OP_QUAD, 16'sd2, 16'sd3, 16'sd1, 0, none});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            push_item(rows[i].op, rows[i].a, rows[i].b, rows[i].c, rows[i].known,
                      rows[i].res);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == QUIET_FROM)
                quiet = 1'b1;
            op  = 1'($urandom_range(0, 1));
            a   = CW'($urandom);
            b   = CW'($urandom);
            c   = CW'($urandom);
            sel = int'($urandom_range(0, 9));
            if (sel == 0)
                a = '0;
            else if (sel <= 2)
            begin
                // perfect square: a*(x-m)^2 gives a repeated root while k*m*m fits in CW bits
                k  = int'($urandom_range(1, 40));
                m  = int'($urandom_range(0, 80)) - 40;
                if ($urandom_range(0, 1))
                    k = -k;
                op = OP_QUAD;
                a  = CW'(k);
                b  = CW'(-2 * k * m);
                c  = CW'(k * m * m);
            end
            else if (sel <= 4)
            begin
                a = CW'(int'($urandom_range(0, 200)) - 100);
                b = CW'(int'($urandom_range(0, 200)) - 100);
                c = CW'(int'($urandom_range(0, 200)) - 100);
            end
            push_item(op, a, b, c, 0, none);
        end
        in_ch.valid <= 1'b0;

        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d items, checked %0d results", n_sent, n_seen);
        $display("two real %0d, repeated %0d, complex %0d, lead zero %0d, linear %0d",
                 n_by_status[ST_TWO_REAL], n_by_status[ST_REPEATED],
                 n_by_status[ST_COMPLEX], n_by_status[ST_LEAD_ZERO],
                 n_by_status[ST_LINEAR]);
        if (n_fail == 0 && pending_roots.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
